/* hdl/ngfe_pkg.sv */
// Shared types, character codes and limits for the GGA field extractor.
`timescale 1ns / 1ps

package ngfe_pkg;

    // field widths
    localparam int CH_W    = 8;
    localparam int FLD_W   = 4;
    localparam int CIF_W   = 2;
    localparam int MI_W    = 2;
    localparam int TIME_W  = 30;
    localparam int LATD_W  = 7;
    localparam int LOND_W  = 10;
    localparam int MIN_W   = 20;
    localparam int HDOP_W  = 27;
    localparam int DECS_W  = 4;
    localparam int LAT_W   = 27;
    localparam int LON_W   = 31;
    localparam int ACC_W   = 30;
    localparam int OUT_W   = 120;

    // saturation limits and scale
    localparam logic [ACC_W-1:0] TIME_MAX  = 30'd999999999;
    localparam logic [ACC_W-1:0] HDOP_MAX  = 30'd99999999;
    localparam logic [ACC_W-1:0] MIN_MAX   = 30'd999999;
    localparam logic [FLD_W-1:0] FIELD_MAX = 4'd15;
    localparam logic [DECS_W-1:0] DECS_MAX = 4'd15;
    localparam logic [CIF_W-1:0] CIF_MAX   = 2'd3;
    localparam logic [MI_W-1:0]  MI_LAST   = 2'd2;
    localparam logic [LON_W-1:0] DEG_SCALE = 31'd600000;

    // characters
    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_G      = 8'h47;
    localparam logic [CH_W-1:0] CH_A      = 8'h41;
    localparam logic [CH_W-1:0] CH_N      = 8'h4E;
    localparam logic [CH_W-1:0] CH_S      = 8'h53;
    localparam logic [CH_W-1:0] CH_E      = 8'h45;
    localparam logic [CH_W-1:0] CH_W_LTR  = 8'h57;

    // sentence field numbers (counted by commas)
    localparam logic [FLD_W-1:0] FLD_TAG  = 4'd0;
    localparam logic [FLD_W-1:0] FLD_TIME = 4'd1;
    localparam logic [FLD_W-1:0] FLD_LAT  = 4'd2;
    localparam logic [FLD_W-1:0] FLD_NS   = 4'd3;
    localparam logic [FLD_W-1:0] FLD_LON  = 4'd4;
    localparam logic [FLD_W-1:0] FLD_EW   = 4'd5;
    localparam logic [FLD_W-1:0] FLD_HDOP = 4'd8;

    // leading digits that go to degrees
    localparam logic [CIF_W-1:0] LAT_DEG_DIGITS = 2'd2;
    localparam logic [CIF_W-1:0] LON_DEG_DIGITS = 2'd3;

    // end-of-sentence snapshot handed from parser to formatter
    typedef struct packed {
        logic                is_gga;
        logic [TIME_W-1:0]   time_acc;
        logic [LATD_W-1:0]   lat_deg;
        logic [MIN_W-1:0]    lat_min;
        logic [LOND_W-1:0]   lon_deg;
        logic [MIN_W-1:0]    lon_min;
        logic                south;
        logic                west;
        logic [HDOP_W-1:0]   hdop_acc;
        logic [DECS_W-1:0]   hdop_decs;
    } ngfe_snap_t;

    // acc*10 + dig, clamped at limit
    function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [3:0] dig,
                                                    input logic [ACC_W-1:0] limit);
        logic [ACC_W+3:0] v;
        v = (ACC_W+4)'(acc) * (ACC_W+4)'(10) + (ACC_W+4)'(dig);
        return (v > (ACC_W+4)'(limit)) ? limit : v[ACC_W-1:0];
    endfunction

endpackage

/* hdl/ngfe_parser.sv */
// Byte parser: field tracking, tag match, digit accumulation, end-of-sentence snapshot.
`timescale 1ns / 1ps

module ngfe_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     beat_valid,
    output logic                     beat_ready,
    input  logic [ngfe_pkg::CH_W-1:0] beat_ch,
    input  logic                     beat_last,
    output logic                     snap_valid,
    input  logic                     snap_ready,
    output ngfe_pkg::ngfe_snap_t     snap
);
    import ngfe_pkg::*;

    logic [FLD_W-1:0]  fld_reg, fld_next;
    logic [CIF_W-1:0]  cif_reg, cif_next;
    logic              first_reg, first_next;
    logic              dollar_reg, dollar_next;
    logic [MI_W-1:0]   mi_reg, mi_next;
    logic              tag_reg, tag_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [LATD_W-1:0] latd_reg, latd_next;
    logic [MIN_W-1:0]  latm_reg, latm_next;
    logic [LOND_W-1:0] lond_reg, lond_next;
    logic [MIN_W-1:0]  lonm_reg, lonm_next;
    logic              south_reg, south_next;
    logic              west_reg, west_next;
    logic [HDOP_W-1:0] hdop_reg, hdop_next;
    logic [DECS_W-1:0] decs_reg, decs_next;
    logic              dot_reg, dot_next;

    logic              snap_valid_reg;
    ngfe_snap_t        snap_reg, snap_next;

    logic              accept;
    logic              is_digit;
    logic [3:0]        dval;
    logic [CH_W-1:0]   tag_char;

    assign beat_ready = !snap_valid_reg || snap_ready;
    assign accept     = beat_valid && beat_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    assign is_digit = (beat_ch >= CH_ZERO) && (beat_ch <= CH_NINE);
    assign dval     = is_digit ? beat_ch[3:0] : 4'd0;
    assign tag_char = (mi_reg >= MI_LAST) ? CH_A : CH_G;

    always_comb begin
        fld_next    = fld_reg;
        cif_next    = cif_reg;
        first_next  = first_reg;
        dollar_next = dollar_reg;
        mi_next     = mi_reg;
        tag_next    = tag_reg;
        time_next   = time_reg;
        latd_next   = latd_reg;
        latm_next   = latm_reg;
        lond_next   = lond_reg;
        lonm_next   = lonm_reg;
        south_next  = south_reg;
        west_next   = west_reg;
        hdop_next   = hdop_reg;
        decs_next   = decs_reg;
        dot_next    = dot_reg;

        if (first_reg) begin
            dollar_next = (beat_ch == CH_DOLLAR);
            first_next  = 1'b0;
        end

        // tag matcher: restarts on mismatch, mismatching byte not retried
        if (fld_reg == FLD_TAG && !tag_reg) begin
            if (beat_ch == tag_char) begin
                if (mi_reg >= MI_LAST) begin
                    tag_next = 1'b1;
                    mi_next  = '0;
                end else begin
                    mi_next = mi_reg + 1'b1;
                end
            end else begin
                mi_next = '0;
            end
        end

        if (beat_ch == CH_COMMA) begin
            if (fld_reg < FIELD_MAX) begin
                fld_next = fld_reg + 1'b1;
            end
            cif_next = '0;
        end else if (beat_ch == CH_DOT) begin
            if (fld_reg == FLD_HDOP) begin
                dot_next  = 1'b1;
                decs_next = '0;
            end
        end else begin
            case (fld_reg)
                FLD_TIME: begin
                    if (is_digit) begin
                        time_next = push_digit(time_reg, dval, TIME_MAX);
                    end
                end
                FLD_LAT: begin
                    if (is_digit) begin
                        if (cif_reg < LAT_DEG_DIGITS) begin
                            latd_next = LATD_W'(11'(latd_reg) * 11'd10 + 11'(dval));
                        end else begin
                            latm_next = MIN_W'(push_digit(ACC_W'(latm_reg), dval, MIN_MAX));
                        end
                    end
                end
                FLD_NS: begin
                    if (beat_ch == CH_N) south_next = 1'b0;
                    if (beat_ch == CH_S) south_next = 1'b1;
                end
                FLD_LON: begin
                    if (is_digit) begin
                        if (cif_reg < LON_DEG_DIGITS) begin
                            lond_next = LOND_W'(14'(lond_reg) * 14'd10 + 14'(dval));
                        end else begin
                            lonm_next = MIN_W'(push_digit(ACC_W'(lonm_reg), dval, MIN_MAX));
                        end
                    end
                end
                FLD_EW: begin
                    if (beat_ch == CH_E)     west_next = 1'b0;
                    if (beat_ch == CH_W_LTR) west_next = 1'b1;
                end
                FLD_HDOP: begin
                    if (is_digit) begin
                        hdop_next = HDOP_W'(push_digit(ACC_W'(hdop_reg), dval, HDOP_MAX));
                        if (dot_reg && decs_reg < DECS_MAX) begin
                            decs_next = decs_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (cif_reg < CIF_MAX) begin
                cif_next = cif_reg + 1'b1;
            end
        end
    end

    always_comb begin
        snap_next.is_gga    = dollar_next && tag_next;
        snap_next.time_acc  = time_next;
        snap_next.lat_deg   = latd_next;
        snap_next.lat_min   = latm_next;
        snap_next.lon_deg   = lond_next;
        snap_next.lon_min   = lonm_next;
        snap_next.south     = south_next;
        snap_next.west      = west_next;
        snap_next.hdop_acc  = hdop_next;
        snap_next.hdop_decs = decs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && beat_last)) begin
            fld_reg    <= '0;
            cif_reg    <= '0;
            first_reg  <= 1'b1;
            dollar_reg <= 1'b0;
            mi_reg     <= '0;
            tag_reg    <= 1'b0;
            time_reg   <= '0;
            latd_reg   <= '0;
            latm_reg   <= '0;
            lond_reg   <= '0;
            lonm_reg   <= '0;
            south_reg  <= 1'b0;
            west_reg   <= 1'b0;
            hdop_reg   <= '0;
            decs_reg   <= '0;
            dot_reg    <= 1'b0;
        end else if (accept) begin
            fld_reg    <= fld_next;
            cif_reg    <= cif_next;
            first_reg  <= first_next;
            dollar_reg <= dollar_next;
            mi_reg     <= mi_next;
            tag_reg    <= tag_next;
            time_reg   <= time_next;
            latd_reg   <= latd_next;
            latm_reg   <= latm_next;
            lond_reg   <= lond_next;
            lonm_reg   <= lonm_next;
            south_reg  <= south_next;
            west_reg   <= west_next;
            hdop_reg   <= hdop_next;
            decs_reg   <= decs_next;
            dot_reg    <= dot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (accept && beat_last) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_ready) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && beat_last) begin
            snap_reg <= snap_next;
        end
    end

endmodule

/* hdl/ngfe_format.sv */
// Result formatter: degree scaling, sign, position check, output register.
`timescale 1ns / 1ps

module ngfe_format (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        snap_valid,
    output logic                        snap_ready,
    input  ngfe_pkg::ngfe_snap_t        snap,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ngfe_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tuser
);
    import ngfe_pkg::*;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg;
    logic               load;

    logic [LAT_W-1:0]   lat_mag, lat_val;
    logic [LON_W-1:0]   lon_mag, lon_val;
    logic               pos_valid;

    assign snap_ready = !m_tvalid_reg || m_tready;
    assign load       = snap_valid && snap_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        lat_mag   = LAT_W'(LAT_W'(snap.lat_deg) * LAT_W'(DEG_SCALE)) + LAT_W'(snap.lat_min);
        lon_mag   = LON_W'(snap.lon_deg) * DEG_SCALE + LON_W'(snap.lon_min);
        lat_val   = snap.south ? (LAT_W'(0) - lat_mag) : lat_mag;
        lon_val   = snap.west  ? (LON_W'(0) - lon_mag) : lon_mag;
        pos_valid = (lat_mag != '0) || (lon_mag != '0);
        m_tdata_next = {pos_valid, snap.hdop_decs, snap.hdop_acc,
                        lon_val, lat_val, snap.time_acc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= snap.is_gga;
        end
    end

endmodule

/* hdl/nmea_gga_field_extractor.sv */
// Top level of the NMEA GGA field extractor: byte stream in, one result beat per sentence.
`timescale 1ns / 1ps
//
//  channel | dir | tdata                          | tuser   | tlast
//  --------+-----+--------------------------------+---------+-----------------
//  s_      | in  | [7:0] ch                       | -       | last byte of sentence
//  m_      | out | time/lat/lon/hdop/decs/posval  | is_gga  | -
//
//  Takes one byte beat per cycle whenever downstream keeps up; the per-byte
//  state update is a single registered pass (mult-by-10 accumulate and clamp).
//  The accept of the last byte beat loads the snapshot register; the scaling/sign
//  output register then loads from the snapshot once it has room, which raises
//  m_tvalid.
//  Reset (aresetn low, synchronous) clears the parser state and both valids.
//  Stalls on m_ fill the output register, then the snapshot register; s_tready
//  drops only when both hold a result, so bytes keep flowing with one result
//  waiting.

module nmea_gga_field_extractor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tlast,   // last byte of the sentence
    output logic         m_tvalid,
    input  logic         m_tready,
    // [29:0] utc_time, [56:30] latitude, [87:57] longitude, [114:88] hdop_value,
    // [118:115] hdop_decimals, [119] position_valid
    output logic [119:0] m_tdata,
    output logic         m_tuser    // [0] is_gga
);
    import ngfe_pkg::*;

    logic        snap_valid;
    logic        snap_ready;
    ngfe_snap_t  snap;

    // per-byte parser with end-of-sentence snapshot
    ngfe_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (s_tvalid),
        .beat_ready (s_tready),
        .beat_ch    (s_tdata),
        .beat_last  (s_tlast),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    // fixed-point positions and result register
    ngfe_format u_format (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* dv/nmea_gga_field_extractor_tb.sv */
// Self-checking testbench for the NMEA GGA field extractor, with its own sentence parser model.
`timescale 1ns / 1ps

module nmea_gga_field_extractor_tb;

    import ngfe_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;     // idle wait once every expected result is in
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned BYTE_TARGET   = 1350;  // directed and random bytes together
    localparam int unsigned FIX_TARGET    = 48;

    // One result beat as it sits in m_tdata, lowest field last.
    typedef struct packed {
        logic              pos_valid;   // [119]
        logic [DECS_W-1:0] hdop_decs;   // [118:115]
        logic [HDOP_W-1:0] hdop;        // [114:88]
        logic [LON_W-1:0]  lon;         // [87:57]
        logic [LAT_W-1:0]  lat;         // [56:30]
        logic [TIME_W-1:0] utc;         // [29:0]
    } fix_word_t;

    typedef struct packed {
        logic      is_gga;              // travels on m_tuser
        fix_word_t w;
    } gga_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;      // [7:0] ch
    logic         s_tlast = 1'b0;       // last byte of the sentence
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;              // utc, lat, lon, hdop, decimals, position_valid
    logic         m_tuser;              // [0] is_gga

    nmea_gga_field_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sentence parser model: state of the sentence in flight
    // ------------------------------------------------------------------
    logic [FLD_W-1:0]  fld_num;
    logic [CIF_W-1:0]  fld_pos;        // non-dot bytes seen in this field, saturates
    logic              first_byte;
    logic              saw_dollar;
    logic [MI_W-1:0]   tag_pos;
    logic              tag_hit;
    logic [ACC_W-1:0]  utc_acc;
    logic [LATD_W-1:0] lat_deg;
    logic [ACC_W-1:0]  lat_min;
    logic [LOND_W-1:0] lon_deg;
    logic [ACC_W-1:0]  lon_min;
    logic              is_south;
    logic              is_west;
    logic [ACC_W-1:0]  hdop_digits;
    logic [DECS_W-1:0] hdop_frac;
    logic              hdop_dot;

    gga_result_t   pending_fixes[$];   // expected result beats, oldest first
    gga_result_t   predicted;
    logic [7:0]    line_buf[$];        // sentence being built for sending

    int unsigned   bytes_accepted = 0;
    int unsigned   fixes_received = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   gap_max = 8;        // sender wait per beat drawn from 0..gap_max
    int unsigned   stall_max = 8;      // receiver wait per beat drawn from 0..stall_max
    int unsigned   stall_left = 0;
    int unsigned   hold_request = 0;   // long receiver hold-off, picked up below
    int unsigned   hold_left = 0;

    function automatic void clear_sentence();
        fld_num = '0; fld_pos = '0; first_byte = 1'b1; saw_dollar = 1'b0;
        tag_pos = '0; tag_hit = 1'b0; utc_acc = '0;
        lat_deg = '0; lat_min = '0; lon_deg = '0; lon_min = '0;
        is_south = 1'b0; is_west = 1'b0;
        hdop_digits = '0; hdop_frac = '0; hdop_dot = 1'b0;
    endfunction

    // acc*10 + d, held at cap instead of wrapping
    function automatic logic [ACC_W-1:0] append_digit(input logic [ACC_W-1:0] acc,
                                                      input logic [3:0] d,
                                                      input logic [ACC_W-1:0] cap);
        logic [ACC_W+3:0] sum;
        sum = {4'd0, acc} * 10 + d;
        return (sum > {4'd0, cap}) ? cap : sum[ACC_W-1:0];
    endfunction

    // Folds one byte into the sentence state; returns 1 with the result on the last byte.
    function automatic logic gga_parse_byte(input logic [7:0] ch, input logic is_last,
                                            output gga_result_t res);
        logic        isdig;
        logic [3:0]  d;
        logic [7:0]  tag_ch;
        logic [63:0] lat_mag;
        logic [63:0] lon_mag;
        isdig = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d = isdig ? 4'(ch - CH_ZERO) : 4'd0;
        res = '0;

        if (first_byte) begin
            saw_dollar = (ch == CH_DOLLAR);
            first_byte = 1'b0;
        end

        // "GGA" matcher: a mismatch restarts it and the byte is not tried again
        if (fld_num == FLD_TAG && !tag_hit) begin
            tag_ch = (tag_pos == MI_LAST) ? CH_A : CH_G;
            if (ch == tag_ch) begin
                if (tag_pos == MI_LAST) begin
                    tag_hit = 1'b1;
                    tag_pos = '0;
                end else begin
                    tag_pos = tag_pos + 1'b1;
                end
            end else begin
                tag_pos = '0;
            end
        end

        if (ch == CH_COMMA) begin
            if (fld_num != FIELD_MAX) fld_num = fld_num + 1'b1;
            fld_pos = '0;
        end else if (ch == CH_DOT) begin
            // every dot in the HDOP field restarts the decimal count
            if (fld_num == FLD_HDOP) begin
                hdop_dot = 1'b1;
                hdop_frac = '0;
            end
        end else begin
            case (fld_num)
                FLD_TIME: if (isdig) utc_acc = append_digit(utc_acc, d, TIME_MAX);
                FLD_LAT: if (isdig) begin
                    if (fld_pos < LAT_DEG_DIGITS) lat_deg = LATD_W'(lat_deg * 10 + d);
                    else lat_min = append_digit(lat_min, d, MIN_MAX);
                end
                FLD_NS: begin
                    if (ch == CH_N) is_south = 1'b0;
                    if (ch == CH_S) is_south = 1'b1;
                end
                FLD_LON: if (isdig) begin
                    if (fld_pos < LON_DEG_DIGITS) lon_deg = LOND_W'(lon_deg * 10 + d);
                    else lon_min = append_digit(lon_min, d, MIN_MAX);
                end
                FLD_EW: begin
                    if (ch == CH_E) is_west = 1'b0;
                    if (ch == CH_W_LTR) is_west = 1'b1;
                end
                FLD_HDOP: if (isdig) begin
                    hdop_digits = append_digit(hdop_digits, d, HDOP_MAX);
                    if (hdop_dot && hdop_frac != DECS_MAX) hdop_frac = hdop_frac + 1'b1;
                end
                default: ;
            endcase
            if (fld_pos != CIF_MAX) fld_pos = fld_pos + 1'b1;
        end

        if (!is_last) return 1'b0;

        lat_mag = 64'(lat_deg) * 64'(DEG_SCALE) + 64'(lat_min);
        lon_mag = 64'(lon_deg) * 64'(DEG_SCALE) + 64'(lon_min);
        res.is_gga      = saw_dollar & tag_hit;
        res.w.utc       = utc_acc[TIME_W-1:0];
        res.w.lat       = LAT_W'(is_south ? 64'd0 - lat_mag : lat_mag);
        res.w.lon       = LON_W'(is_west ? 64'd0 - lon_mag : lon_mag);
        res.w.hdop      = hdop_digits[HDOP_W-1:0];
        res.w.hdop_decs = hdop_frac;
        res.w.pos_valid = (lat_mag != 64'd0) || (lon_mag != 64'd0);
        clear_sentence();
        return 1'b1;
    endfunction

    // Every accepted byte beat goes through the model.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            bytes_accepted++;
            if (gga_parse_byte(s_tdata, s_tlast, predicted)) pending_fixes.push_back(predicted);
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        gga_result_t want;
        gga_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            fixes_received++;
            stall_left = $urandom_range(0, stall_max);
            got.w = m_tdata;
            got.is_gga = m_tuser;
            if (pending_fixes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result beat with nothing expected: tuser %0h tdata %0h",
                             m_tuser, m_tdata);
            end else begin
                want = pending_fixes.pop_front();
                check_field("is_gga", 64'(want.is_gga), 64'(got.is_gga));
                check_field("utc_time", 64'(want.w.utc), 64'(got.w.utc));
                check_field("latitude", 64'(want.w.lat), 64'(got.w.lat));
                check_field("longitude", 64'(want.w.lon), 64'(got.w.lon));
                check_field("hdop_value", 64'(want.w.hdop), 64'(got.w.hdop));
                check_field("hdop_decimals", 64'(want.w.hdop_decs),
                            64'(got.w.hdop_decs));
                check_field("position_valid", 64'(want.w.pos_valid),
                            64'(got.w.pos_valid));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte sender and sentence builders
    // ------------------------------------------------------------------

    // Offers one byte beat and returns at the edge that accepts it; valid stays
    // up so a back-to-back beat needs no second assignment in one step.
    task automatic send_byte(input logic [7:0] ch, input logic is_last);
        int unsigned gap;
        @(negedge aclk);
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // Drops valid, waits out every expected beat, then lets the pipeline settle.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_digits(input int unsigned n);
        repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // usual length most of the time, otherwise anything in lo..hi
    function automatic int unsigned sized(input int unsigned usual, input int unsigned lo,
                                          input int unsigned hi);
        return ($urandom_range(0, 4) != 0) ? usual : $urandom_range(lo, hi);
    endfunction

    // Mostly well-formed GGA with random content; lengths stretch past the
    // clamps now and then, and some lines get a stray byte or are cut short.
    task automatic build_gga_line();
        int unsigned pick;
        int unsigned cut;
        line_buf.delete();
        put_str("$");
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: put_str("GP");
            6, 7:             put_str("GN");
            8:                put_str("GG");    // GGGGA never completes the tag
            default:          put_str("G");
        endcase
        put_str("GGA,");

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            put_digits(6);
            put_str(".");
            put_digits($urandom_range(0, 3));
        end else if (pick < 9) begin
            put_digits($urandom_range(9, 12));  // runs into the time clamp
        end
        put_str(",");

        put_digits(sized(4, 0, 5));
        put_str(".");
        put_digits(sized(4, 0, 7));
        put_str(",");
        case ($urandom_range(0, 5))
            0, 1:    put_str("N");
            2, 3:    put_str("S");
            4:       put_str("NS");
            default: put_str("SN");
        endcase
        put_str(",");

        put_digits(sized(5, 0, 6));
        put_str(".");
        put_digits(sized(4, 0, 7));
        put_str(",");
        case ($urandom_range(0, 5))
            0, 1:    put_str("E");
            2, 3:    put_str("W");
            4:       put_str("EW");
            default: put_str("WE");
        endcase
        put_str(",");

        put_digits(1);
        put_str(",");
        put_digits(2);
        put_str(",");

        put_digits(sized(1, 0, 3));
        case ($urandom_range(0, 9))
            7: ;
            8: begin
                put_str(".");
                put_digits($urandom_range(0, 2));
                put_str(".");
                put_digits($urandom_range(0, 3));
            end
            9: begin
                put_str(".");
                put_digits($urandom_range(15, 18));  // decimal count and value clamp
            end
            default: begin
                put_str(".");
                put_digits(sized(1, 0, 3));
            end
        endcase

        pick = $urandom_range(0, 9);
        if (pick < 4) put_str(",545.4,M,46.9,M,,*47");
        else if (pick < 6) repeat ($urandom_range(6, 16)) put_str(",");

        if ($urandom_range(0, 4) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, line_buf.size());
            while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
    endtask

    task automatic build_noise_line();
        line_buf.delete();
        repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-byte sentences, including the lowest and highest byte values.
    task automatic test_single_byte_lines();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(CH_DOLLAR, 1'b1);
        send_byte(CH_NINE, 1'b1);
    endtask

    // Tag found without a leading dollar, and a broken match that must not recover.
    task automatic test_tag_matcher();
        put_str("GGA$");
        send_line();
        put_str("$GGGA");
        send_line();
    endtask

    // Short fields, doubled sign letters (the later one wins) and a twice-dotted HDOP.
    task automatic test_fields_and_signs();
        put_str("$GGA,1,2.3,NS,4,EW,,,1.2.34");
        send_line();
        wait_for_results();
    endtask

    // Receiver holds off while the sender streams one-byte sentences back to back,
    // so both result registers fill and s_tready drops.
    task automatic test_output_backpressure();
        gap_max = 0;
        hold_request = 150;
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1);
        put_str("$GPGGA,1,4916.45,N,12311.12,W,,,2.5");
        send_line();
        wait_for_results();
        gap_max = 8;
    endtask

    // Sender goes quiet after each sentence until its result is in.
    task automatic test_pause_until_drained();
        repeat (3) begin
            build_gga_line();
            send_line();
            wait_for_results();
        end
    endtask

    // Random sentences; the idle ranges flip between 0 and 8 every few lines so
    // some stretches run with no gaps at all.
    task automatic test_random_sentences();
        int unsigned lines;
        lines = 0;
        while (bytes_accepted < BYTE_TARGET || fixes_received < FIX_TARGET) begin
            if (lines % 6 == 0) begin
                gap_max   = $urandom_range(0, 1) ? 8 : 0;
                stall_max = $urandom_range(0, 1) ? 8 : 0;
            end
            if ($urandom_range(0, 9) < 8) build_gga_line();
            else build_noise_line();
            send_line();
            lines++;
        end
        gap_max = 8;
        stall_max = 8;
    endtask

    initial begin
        clear_sentence();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_byte_lines();
        test_tag_matcher();
        test_fields_and_signs();
        test_output_backpressure();
        test_pause_until_drained();
        test_random_sentences();
        wait_for_results();

        if (mismatch_count == 0 && pending_fixes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
